FILE: src/hdr_pkg.sv
// shared types, constants and rate table of the heat detector
package hdr_pkg;

  localparam int HISTORY_DEPTH = 31;
  localparam int RATE_ENTRIES  = 6;
  localparam int MATCH_W       = $clog2(RATE_ENTRIES + 1);

  typedef logic [15:0] sample_t;
  typedef sample_t [HISTORY_DEPTH-1:0] hist_view_t;
  typedef logic [MATCH_W-1:0] match_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ALARM_LEVEL      = 3'd0,
    REG_HIGH_ALARM_LEVEL = 3'd1,
    REG_STATIC_DELTA     = 3'd2,
    REG_VALID_LOW        = 3'd3,
    REG_VALID_HIGH       = 3'd4,
    REG_PRESS_MIN_MS     = 3'd5,
    REG_PRESS_MAX_MS     = 3'd6
  } reg_idx_t;

  localparam logic               REQ_SAMPLE = 1'b0;
  localparam logic signed [14:0] RST_ALARM_LEVEL      = 15'sd3000;
  localparam logic signed [14:0] RST_HIGH_ALARM_LEVEL = 15'sd3200;
  localparam logic        [13:0] RST_STATIC_DELTA     = 14'd200;
  localparam logic signed [15:0] RST_VALID_LOW        = -16'sd4000;
  localparam logic signed [15:0] RST_VALID_HIGH       = 16'sd8500;
  localparam logic        [15:0] RST_PRESS_MIN_MS     = 16'd2500;
  localparam logic        [15:0] RST_PRESS_MAX_MS     = 16'd4500;

  localparam logic signed [15:0] REPORT_LOW  = -16'sd4000;
  localparam logic signed [15:0] REPORT_HIGH = 16'sd8500;

  // lag / threshold pairs, scanned in order
  localparam int RATE_LAG [RATE_ENTRIES] = '{0, 21, 20, 10, 29, 29};
  localparam logic signed [16:0] RATE_LIMIT [RATE_ENTRIES] =
    '{17'sd2900, 17'sd2100, 17'sd2000, 17'sd1000, 17'sd2000, 17'sd3000};

endpackage

FILE: src/hdr_cell.sv
// one history cell: holds a sample and hands it to its neighbor on shift
module hdr_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  hdr_pkg::sample_t d_in,
  output hdr_pkg::sample_t q_out
);

  hdr_pkg::sample_t q_r;
  hdr_pkg::sample_t q_nxt;

  always_comb begin
    q_nxt = shift_en ? d_in : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q_out = q_r;

endmodule

FILE: src/hdr_rate_eval.sv
// rate-of-rise table: fixed-tap compares and first-match select
module hdr_rate_eval (
  input  hdr_pkg::hist_view_t view,
  output hdr_pkg::match_t     match
);

  logic [hdr_pkg::RATE_ENTRIES-1:0] hit;

  for (genvar k = 0; k < hdr_pkg::RATE_ENTRIES; k++) begin : g_entry
    localparam int LAG = hdr_pkg::RATE_LAG[k];
    if (LAG < hdr_pkg::HISTORY_DEPTH) begin : g_tap
      logic signed [16:0] diff;
      // both samples read as unsigned patterns
      assign diff = $signed({1'b0, view[hdr_pkg::HISTORY_DEPTH-1]})
                  - $signed({1'b0, view[LAG]});
      assign hit[k] = diff > hdr_pkg::RATE_LIMIT[k];
    end else begin : g_none
      assign hit[k] = 1'b0;
    end
  end

  always_comb begin
    match = '0;
    for (int k = hdr_pkg::RATE_ENTRIES - 1; k >= 0; k--) begin
      if (hit[k]) begin
        match = hdr_pkg::MATCH_W'(k + 1);
      end
    end
  end

endmodule

FILE: src/heat_detector_rate_of_rise_core.sv
// heat detector top: fixed-temperature alert, rate-of-rise table, alarm latch
//
// input channel: one word per tick. in_tuser selects the kind: 0 is a sample
// tick carrying a temperature in hundredths of a degree, 1 is a reset button
// press carrying its duration in ms. every input word yields one result word.
// result channel: held temperature, alert level, alert rising edge, first
// matching rate table entry and the alarm latch after that word.
// the result is valid in the cycle after the input is accepted. throughput is
// one word per cycle unless the receiver stalls: the sample history is a chain
// of register cells shifting together; the six table compares read fixed taps.
// the result sits in one output register; a new word is accepted whenever that
// register is empty or being taken in the same cycle, so a stalled receiver
// stalls the input only while the result waits.
// configuration writes land on the cycle cfg_we is high; unknown indexes are
// dropped. reset (rst_n low, synchronous) clears history, alert, latch and
// held temperature and loads the register defaults.
module heat_detector_rate_of_rise_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // temperature[15:0], press_ms[31:16]
  input  logic        in_tuser,   // req_type[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // reported_temp[14:0], alert[15], alert_rose[16], rate_match[19:17],
  // alarm_latched[20], zero[23:21]
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int DEPTH = hdr_pkg::HISTORY_DEPTH;

  // configuration
  logic signed [14:0] alarm_level_r;
  logic signed [14:0] high_alarm_level_r;
  logic        [13:0] static_delta_r;
  logic signed [15:0] valid_low_r;
  logic signed [15:0] valid_high_r;
  logic        [15:0] press_min_r;
  logic        [15:0] press_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_level_r      <= hdr_pkg::RST_ALARM_LEVEL;
      high_alarm_level_r <= hdr_pkg::RST_HIGH_ALARM_LEVEL;
      static_delta_r     <= hdr_pkg::RST_STATIC_DELTA;
      valid_low_r        <= hdr_pkg::RST_VALID_LOW;
      valid_high_r       <= hdr_pkg::RST_VALID_HIGH;
      press_min_r        <= hdr_pkg::RST_PRESS_MIN_MS;
      press_max_r        <= hdr_pkg::RST_PRESS_MAX_MS;
    end else if (cfg_we) begin
      case (hdr_pkg::reg_idx_t'(cfg_index))
        hdr_pkg::REG_ALARM_LEVEL:      alarm_level_r      <= cfg_wdata[14:0];
        hdr_pkg::REG_HIGH_ALARM_LEVEL: high_alarm_level_r <= cfg_wdata[14:0];
        hdr_pkg::REG_STATIC_DELTA:     static_delta_r     <= cfg_wdata[13:0];
        hdr_pkg::REG_VALID_LOW:        valid_low_r        <= cfg_wdata;
        hdr_pkg::REG_VALID_HIGH:       valid_high_r       <= cfg_wdata;
        hdr_pkg::REG_PRESS_MIN_MS:     press_min_r        <= cfg_wdata;
        hdr_pkg::REG_PRESS_MAX_MS:     press_max_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake
  logic out_tvalid_r;
  logic in_fire;
  logic is_sample;

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign is_sample = (in_tuser == hdr_pkg::REQ_SAMPLE);

  // range check
  logic signed [15:0] temp_raw;
  logic signed [15:0] temp_chk;
  logic        [15:0] press_ms;

  assign temp_raw = $signed(in_tdata[15:0]);
  assign press_ms = in_tdata[31:16];
  assign temp_chk = (temp_raw < valid_low_r || temp_raw > valid_high_r) ? 16'sd0 : temp_raw;

  // history chain
  hdr_pkg::sample_t   hist_q [DEPTH-1];
  hdr_pkg::hist_view_t view;
  logic               shift_en;

  assign shift_en = in_fire && is_sample;

  for (genvar i = 0; i < DEPTH - 1; i++) begin : g_cell
    hdr_pkg::sample_t d_in;
    if (i == 0) begin : g_head
      assign d_in = temp_chk;
    end else begin : g_body
      assign d_in = hist_q[i-1];
    end
    hdr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (d_in),
      .q_out    (hist_q[i])
    );
  end

  // history as it reads after this sample is shifted in
  always_comb begin
    view[0] = temp_chk;
    for (int i = 1; i < DEPTH; i++) begin
      view[i] = hist_q[i-1];
    end
  end

  hdr_pkg::match_t match;

  hdr_rate_eval u_rate (
    .view  (view),
    .match (match)
  );

  // fixed-temperature alert
  logic signed [15:0] rise;
  logic               alert_now;

  assign rise = $signed(temp_chk - view[DEPTH-1]);
  assign alert_now = (temp_chk >= 16'(alarm_level_r)) &&
                     ((rise < $signed({2'b00, static_delta_r})) ||
                      (temp_chk >= 16'(high_alarm_level_r)));

  // state
  logic               alert_r, alert_nxt;
  logic               latch_r, latch_nxt;
  logic signed [14:0] held_r,  held_nxt;
  logic               rose;
  hdr_pkg::match_t    match_item;

  always_comb begin
    alert_nxt  = alert_r;
    latch_nxt  = latch_r;
    held_nxt   = held_r;
    rose       = 1'b0;
    match_item = '0;
    if (in_fire) begin
      if (is_sample) begin
        rose       = alert_now && !alert_r;
        match_item = match;
        alert_nxt  = alert_now;
        if (rose || match != '0) begin
          latch_nxt = 1'b1;
        end
        if (temp_chk >= hdr_pkg::REPORT_LOW && temp_chk <= hdr_pkg::REPORT_HIGH) begin
          held_nxt = temp_chk[14:0];
        end
      end else if (press_ms > press_min_r && press_ms < press_max_r) begin
        latch_nxt = 1'b0;
      end
    end
  end

  logic [23:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alert_r      <= 1'b0;
      latch_r      <= 1'b0;
      held_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      alert_r <= alert_nxt;
      latch_r <= latch_nxt;
      held_r  <= held_nxt;
      if (in_fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {3'b000, latch_nxt, match_item, rose, alert_nxt, held_nxt};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_press_no_rate : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !is_sample |=> out_tvalid && out_tdata[19:17] == '0 && !out_tdata[16])
    else $error("press word reported a rate match or alert edge");

  a_rose_latches : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[15] && out_tdata[20])
    else $error("alert edge without alert or latch");

  a_match_latches : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19:17] != '0 |-> out_tdata[20] && out_tdata[19:17] != 3'd6)
    else $error("rate match inconsistent with latch or table order");

  a_fire_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("accepted word produced no result");

endmodule
